/* rtl/arc_length_path_interpolator_defines.svh */
// Assertion macros used by the checker file of the arc length path interpolator.
`ifndef ARC_LENGTH_PATH_INTERPOLATOR_DEFINES_SVH
`define ARC_LENGTH_PATH_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define ALPI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alpi assertion failed");

// Next-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define ALPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alpi assertion failed");

`endif

/* rtl/alpi_pkg.sv */
// Package with types and constants of the arc length path interpolator.
package alpi_pkg;

    localparam int MAX_POINTS_DEF = 256;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Last iteration indexes of the shared subtractor.
    localparam logic [5:0] SQRT_LAST = 6'd33;
    localparam logic [5:0] DIV_LAST  = 6'd15;

    typedef enum logic [2:0] {
        ST_CLEARED = 3'd0,
        ST_LOADED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_OK      = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_DIFF,
        S_LD_SQ,
        S_SQRT,
        S_ACC,
        S_WRITE,
        S_BS_RD,
        S_BS_CMP,
        S_BS_FIX,
        S_RD_A,
        S_RD_B,
        S_SEG,
        S_DIV,
        S_LP_RA,
        S_LP_RB,
        S_LP_DIFF,
        S_LP_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_roll;
        logic signed [31:0] in_pitch;
        logic signed [31:0] in_yaw;
        logic [31:0]        in_speed_limit;
        logic signed [47:0] arc_position;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_roll;
        logic signed [31:0] out_pitch;
        logic signed [31:0] out_yaw;
        logic [31:0]        out_speed_limit;
        logic [47:0]        total_length;
    } t_out;

    // Operands of the shared arithmetic unit.
    typedef struct packed {
        logic [49:0]        sub_a;
        logic [49:0]        sub_b;
        logic signed [33:0] mul_a;
        logic signed [33:0] mul_b;
    } t_alu_in;

    typedef struct packed {
        logic               ge;
        logic [49:0]        diff;
        logic signed [67:0] prod;
    } t_alu_out;

endpackage

/* rtl/alpi_alu.sv */
// Shared arithmetic unit: one compare-subtract and one signed multiplier.
module alpi_alu (
    input  alpi_pkg::t_alu_in  i_op,
    output alpi_pkg::t_alu_out o_res
);

    // Restoring step for square root and division.
    assign o_res.diff = i_op.sub_a - i_op.sub_b;
    assign o_res.ge   = (i_op.sub_a >= i_op.sub_b);

    // Squares of coordinate deltas and interpolation products.
    assign o_res.prod = i_op.mul_a * i_op.mul_b;

endmodule

/* rtl/alpi_store.sv */
// Waypoint memories: pose words, speed limits and cumulative arc lengths.
module alpi_store #(
    parameter int MAX_POINTS = alpi_pkg::MAX_POINTS_DEF,
    parameter int IW         = $clog2(MAX_POINTS),
    parameter int PAW        = $clog2(MAX_POINTS * 6)
) (
    input  logic           i_clk,
    input  logic [PAW-1:0] i_pose_addr,
    input  logic           i_pose_we,
    input  logic [31:0]    i_pose_wdata,
    output logic [31:0]    o_pose_rdata,
    input  logic [IW-1:0]  i_spd_addr,
    input  logic           i_spd_we,
    input  logic [31:0]    i_spd_wdata,
    output logic [31:0]    o_spd_rdata,
    input  logic [IW-1:0]  i_arc_addr,
    input  logic           i_arc_we,
    input  logic [47:0]    i_arc_wdata,
    output logic [47:0]    o_arc_rdata
);

    logic [31:0] r_pose_mem [MAX_POINTS*6];
    logic [31:0] r_spd_mem  [MAX_POINTS];
    logic [47:0] r_arc_mem  [MAX_POINTS];

    // Pose memory, six words per point.
    always_ff @(posedge i_clk) begin
        if (i_pose_we) begin
            r_pose_mem[i_pose_addr] <= i_pose_wdata;
        end
        o_pose_rdata <= r_pose_mem[i_pose_addr];
    end

    // Speed limit memory.
    always_ff @(posedge i_clk) begin
        if (i_spd_we) begin
            r_spd_mem[i_spd_addr] <= i_spd_wdata;
        end
        o_spd_rdata <= r_spd_mem[i_spd_addr];
    end

    // Cumulative arc memory.
    always_ff @(posedge i_clk) begin
        if (i_arc_we) begin
            r_arc_mem[i_arc_addr] <= i_arc_wdata;
        end
        o_arc_rdata <= r_arc_mem[i_arc_addr];
    end

endmodule

/* rtl/arc_length_path_interpolator.sv */
// Arc length path interpolator: sequencer around one shared arithmetic unit.
// Clear, full load and invalid query go straight to the result; the first load writes
// without a square root; later loads take 34 square root steps on the shared subtractor.
// Query: clamped positions skip the search and divider, else a binary search and the
// 16-step divider, then each word is read through the single read port of the pose memory.
// One word in flight: the next can be taken in the cycle its result is first presented. Reset empties the path.
module arc_length_path_interpolator #(
    parameter int MAX_POINTS = alpi_pkg::MAX_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  alpi_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output alpi_pkg::t_out o_out
);

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int PAW  = $clog2(MAX_POINTS * 6);
    localparam int OUTW = $bits(alpi_pkg::t_out);
    localparam int STW  = $bits(alpi_pkg::t_status);

    alpi_pkg::t_state   r_state, n_state;
    alpi_pkg::t_in      r_in;
    alpi_pkg::t_out     r_res;
    alpi_pkg::t_out     r_out;
    logic               r_out_valid;
    logic [CW-1:0]      r_cnt;
    logic [47:0]        r_acc;
    logic [2:0]         r_k;
    logic [5:0]         r_it;
    logic [67:0]        r_rad;
    logic [35:0]        r_rem;
    logic [33:0]        r_root;
    logic [32:0]        r_d;
    logic [CW-1:0]      r_lo, r_hi;
    logic [IW-1:0]      r_mid, r_a, r_b;
    logic [47:0]        r_arc_a, r_ds, r_drem;
    logic [15:0]        r_t;
    logic signed [33:0] r_p0, r_dd;

    alpi_pkg::t_alu_in  alu_in;
    alpi_pkg::t_alu_out alu_out;

    logic [PAW-1:0] pose_addr;
    logic           pose_we;
    logic [31:0]    pose_wdata, pose_rdata;
    logic [IW-1:0]  spd_addr;
    logic           spd_we;
    logic [31:0]    spd_rdata;
    logic [IW-1:0]  arc_addr;
    logic           arc_we;
    logic [47:0]    arc_rdata;

    logic           accept, out_free;
    logic           is_full, path_ok, s_le0, s_ge_acc;
    alpi_pkg::t_status acc_status;
    logic [IW-1:0]  last_idx, prev_idx, cnt_idx;
    logic [PAW-1:0] prev_base, cnt_base, a_base, b_base;
    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_w, lo_fix;
    logic [37:0]    rem_sh;
    logic [48:0]    acc_sum, ds49, off49;
    logic           seg_ok;
    logic signed [32:0] cdiff;
    logic signed [33:0] p_ext, p_val;
    logic [31:0]    cur_comp;

    assign accept      = i_in_valid && (r_state == alpi_pkg::S_IDLE);
    assign o_in_stall  = (r_state != alpi_pkg::S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Decisions taken when a word is accepted.
    assign is_full  = (r_cnt >= CW'(MAX_POINTS));
    assign path_ok  = (r_cnt >= CW'(2)) && (r_acc != 48'd0);
    assign s_le0    = i_in.arc_position[47] || (i_in.arc_position == 48'sd0);
    assign s_ge_acc = (i_in.arc_position[47:0] >= r_acc);

    // Status of the accepted word.
    always_comb begin
        unique case (i_in.operation)
            alpi_pkg::OP_CLEAR: acc_status = alpi_pkg::ST_CLEARED;
            alpi_pkg::OP_LOAD:  acc_status = is_full ? alpi_pkg::ST_FULL
                                                     : alpi_pkg::ST_LOADED;
            alpi_pkg::OP_QUERY: acc_status = path_ok ? alpi_pkg::ST_OK
                                                     : alpi_pkg::ST_INVALID;
            default:            acc_status = alpi_pkg::ST_INVALID;
        endcase
    end

    // Point indexes and pose word bases (six words per point).
    assign last_idx  = IW'(r_cnt - CW'(1));
    assign prev_idx  = last_idx;
    assign cnt_idx   = IW'(r_cnt);
    assign prev_base = (PAW'(prev_idx) << 2) + (PAW'(prev_idx) << 1);
    assign cnt_base  = (PAW'(cnt_idx) << 2) + (PAW'(cnt_idx) << 1);
    assign a_base    = (PAW'(r_a) << 2) + (PAW'(r_a) << 1);
    assign b_base    = (PAW'(r_b) << 2) + (PAW'(r_b) << 1);

    // Binary search midpoint and final segment index.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_w   = mid_sum[CW:1];
    always_comb begin
        if (r_lo == '0) begin
            lo_fix = CW'(1);
        end else if (r_lo >= r_cnt) begin
            lo_fix = r_cnt - CW'(1);
        end else begin
            lo_fix = r_lo;
        end
    end

    // Square root remainder, arc accumulation and segment checks.
    assign rem_sh  = {r_rem, r_rad[67:66]};
    assign acc_sum = {1'b0, r_acc} + 49'(r_root);
    assign ds49    = {1'b0, arc_rdata} - {1'b0, r_arc_a};
    assign off49   = {1'b0, r_in.arc_position[47:0]} - {1'b0, r_arc_a};
    assign seg_ok  = !ds49[48] && (ds49 != 49'd0) && !off49[48]
                     && (off49[47:0] < ds49[47:0]);

    // Current pose word of the accepted point.
    always_comb begin
        unique case (r_k)
            3'd0:    cur_comp = r_in.in_x;
            3'd1:    cur_comp = r_in.in_y;
            3'd2:    cur_comp = r_in.in_z;
            3'd3:    cur_comp = r_in.in_roll;
            3'd4:    cur_comp = r_in.in_pitch;
            3'd5:    cur_comp = r_in.in_yaw;
            default: cur_comp = r_in.in_speed_limit;
        endcase
    end

    // Coordinate delta against the previous point, and the read value widened.
    assign cdiff = {cur_comp[31], cur_comp} - {pose_rdata[31], pose_rdata};
    assign p_ext = (r_k == 3'd6) ? $signed({2'b00, spd_rdata})
                                 : $signed({{2{pose_rdata[31]}}, pose_rdata});
    assign p_val = r_p0 + $signed(alu_out.prod[49:16]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alpi_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_in.operation)
                        alpi_pkg::OP_LOAD: begin
                            if (is_full) begin
                                n_state = alpi_pkg::S_DONE;
                            end else if (r_cnt == '0) begin
                                n_state = alpi_pkg::S_WRITE;
                            end else begin
                                n_state = alpi_pkg::S_LD_RD;
                            end
                        end
                        alpi_pkg::OP_QUERY: begin
                            if (!path_ok) begin
                                n_state = alpi_pkg::S_DONE;
                            end else if (s_le0 || s_ge_acc) begin
                                n_state = alpi_pkg::S_LP_RA;
                            end else begin
                                n_state = alpi_pkg::S_BS_RD;
                            end
                        end
                        default: n_state = alpi_pkg::S_DONE;
                    endcase
                end
            end
            alpi_pkg::S_LD_RD:   n_state = alpi_pkg::S_LD_DIFF;
            alpi_pkg::S_LD_DIFF: n_state = alpi_pkg::S_LD_SQ;
            alpi_pkg::S_LD_SQ: begin
                n_state = (r_k == 3'd2) ? alpi_pkg::S_SQRT : alpi_pkg::S_LD_RD;
            end
            alpi_pkg::S_SQRT: begin
                if (r_it == alpi_pkg::SQRT_LAST) begin
                    n_state = alpi_pkg::S_ACC;
                end
            end
            alpi_pkg::S_ACC: n_state = alpi_pkg::S_WRITE;
            alpi_pkg::S_WRITE: begin
                if (r_k == 3'd5) begin
                    n_state = alpi_pkg::S_DONE;
                end
            end
            alpi_pkg::S_BS_RD: begin
                n_state = (r_lo < r_hi) ? alpi_pkg::S_BS_CMP : alpi_pkg::S_BS_FIX;
            end
            alpi_pkg::S_BS_CMP: n_state = alpi_pkg::S_BS_RD;
            alpi_pkg::S_BS_FIX: n_state = alpi_pkg::S_RD_A;
            alpi_pkg::S_RD_A:   n_state = alpi_pkg::S_RD_B;
            alpi_pkg::S_RD_B:   n_state = alpi_pkg::S_SEG;
            alpi_pkg::S_SEG: begin
                n_state = seg_ok ? alpi_pkg::S_DIV : alpi_pkg::S_LP_RA;
            end
            alpi_pkg::S_DIV: begin
                if (r_it == alpi_pkg::DIV_LAST) begin
                    n_state = alpi_pkg::S_LP_RA;
                end
            end
            alpi_pkg::S_LP_RA:   n_state = alpi_pkg::S_LP_RB;
            alpi_pkg::S_LP_RB:   n_state = alpi_pkg::S_LP_DIFF;
            alpi_pkg::S_LP_DIFF: n_state = alpi_pkg::S_LP_MUL;
            alpi_pkg::S_LP_MUL: begin
                n_state = (r_k == 3'd6) ? alpi_pkg::S_DONE : alpi_pkg::S_LP_RA;
            end
            alpi_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = alpi_pkg::S_IDLE;
                end
            end
            default: n_state = alpi_pkg::S_IDLE;
        endcase
    end

    // Memory ports and shared unit operands.
    always_comb begin
        pose_addr  = a_base + PAW'(r_k);
        pose_we    = 1'b0;
        pose_wdata = cur_comp;
        spd_addr   = r_a;
        spd_we     = 1'b0;
        arc_addr   = r_a;
        arc_we     = 1'b0;
        alu_in     = '0;
        unique case (r_state)
            alpi_pkg::S_LD_RD: pose_addr = prev_base + PAW'(r_k);
            alpi_pkg::S_LD_SQ: begin
                alu_in.mul_a = $signed({1'b0, r_d});
                alu_in.mul_b = $signed({1'b0, r_d});
            end
            alpi_pkg::S_SQRT: begin
                alu_in.sub_a = 50'(rem_sh);
                alu_in.sub_b = 50'({r_root, 2'b01});
            end
            alpi_pkg::S_WRITE: begin
                pose_addr = cnt_base + PAW'(r_k);
                pose_we   = 1'b1;
                spd_addr  = cnt_idx;
                spd_we    = (r_k == 3'd0);
                arc_addr  = cnt_idx;
                arc_we    = (r_k == 3'd0);
            end
            alpi_pkg::S_BS_RD: arc_addr = mid_w[IW-1:0];
            alpi_pkg::S_RD_B:  arc_addr = r_b;
            alpi_pkg::S_DIV: begin
                alu_in.sub_a = 50'({r_drem, 1'b0});
                alu_in.sub_b = 50'(r_ds);
            end
            alpi_pkg::S_LP_RB: begin
                pose_addr = b_base + PAW'(r_k);
                spd_addr  = r_b;
            end
            alpi_pkg::S_LP_MUL: begin
                alu_in.mul_a = r_dd;
                alu_in.mul_b = $signed({18'd0, r_t});
            end
            default: begin
                pose_addr = a_base + PAW'(r_k);
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alpi_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == alpi_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Path length and point count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_acc <= '0;
        end else begin
            if (accept && i_in.operation == alpi_pkg::OP_CLEAR) begin
                r_cnt <= '0;
                r_acc <= '0;
            end
            if (r_state == alpi_pkg::S_ACC) begin
                r_acc <= acc_sum[48] ? '1 : acc_sum[47:0];
            end
            if (r_state == alpi_pkg::S_WRITE && r_k == 3'd5) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            alpi_pkg::S_IDLE: begin
                if (accept) begin
                    r_in  <= i_in;
                    r_res <= {acc_status, {(OUTW - STW){1'b0}}};
                    r_k   <= '0;
                    r_rad <= '0;
                    r_rem <= '0;
                    r_root <= '0;
                    r_it  <= '0;
                    r_t   <= '0;
                    r_lo  <= '0;
                    r_hi  <= r_cnt;
                    r_a   <= s_le0 ? '0 : last_idx;
                    r_b   <= s_le0 ? '0 : last_idx;
                end
            end
            alpi_pkg::S_LD_DIFF: r_d <= cdiff[32] ? 33'(-cdiff) : 33'(cdiff);
            alpi_pkg::S_LD_SQ: begin
                r_rad <= r_rad + alu_out.prod[67:0];
                r_k   <= r_k + 3'd1;
            end
            alpi_pkg::S_SQRT: begin
                if (alu_out.ge) begin
                    r_rem  <= alu_out.diff[35:0];
                    r_root <= {r_root[32:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[35:0];
                    r_root <= {r_root[32:0], 1'b0};
                end
                r_rad <= {r_rad[65:0], 2'b00};
                r_it  <= r_it + 6'd1;
            end
            alpi_pkg::S_ACC: r_k <= '0;
            alpi_pkg::S_WRITE: r_k <= r_k + 3'd1;
            alpi_pkg::S_BS_RD: r_mid <= mid_w[IW-1:0];
            alpi_pkg::S_BS_CMP: begin
                if (r_in.arc_position[47:0] < arc_rdata) begin
                    r_hi <= CW'(r_mid);
                end else begin
                    r_lo <= CW'(r_mid) + CW'(1);
                end
            end
            alpi_pkg::S_BS_FIX: begin
                r_b <= IW'(lo_fix);
                r_a <= IW'(lo_fix - CW'(1));
            end
            alpi_pkg::S_RD_B: r_arc_a <= arc_rdata;
            alpi_pkg::S_SEG: begin
                r_ds   <= ds49[47:0];
                r_drem <= off49[47:0];
                r_it   <= '0;
                r_k    <= '0;
            end
            alpi_pkg::S_DIV: begin
                if (alu_out.ge) begin
                    r_drem <= alu_out.diff[47:0];
                end else begin
                    r_drem <= {r_drem[46:0], 1'b0};
                end
                r_t  <= {r_t[14:0], alu_out.ge};
                r_it <= r_it + 6'd1;
            end
            alpi_pkg::S_LP_RB:   r_p0 <= p_ext;
            alpi_pkg::S_LP_DIFF: r_dd <= p_ext - r_p0;
            alpi_pkg::S_LP_MUL: begin
                unique case (r_k)
                    3'd0:    r_res.out_x     <= p_val[31:0];
                    3'd1:    r_res.out_y     <= p_val[31:0];
                    3'd2:    r_res.out_z     <= p_val[31:0];
                    3'd3:    r_res.out_roll  <= p_val[31:0];
                    3'd4:    r_res.out_pitch <= p_val[31:0];
                    3'd5:    r_res.out_yaw   <= p_val[31:0];
                    default: r_res.out_speed_limit <= p_val[31:0];
                endcase
                r_k <= r_k + 3'd1;
            end
            alpi_pkg::S_DONE: begin
                // The result word always carries the current path length.
                if (out_free) begin
                    r_out <= {r_res[OUTW-1:48], r_acc};
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    alpi_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    alpi_store #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW),
        .PAW        (PAW)
    ) u_store (
        .i_clk        (i_clk),
        .i_pose_addr  (pose_addr),
        .i_pose_we    (pose_we),
        .i_pose_wdata (pose_wdata),
        .o_pose_rdata (pose_rdata),
        .i_spd_addr   (spd_addr),
        .i_spd_we     (spd_we),
        .i_spd_wdata  (r_in.in_speed_limit),
        .o_spd_rdata  (spd_rdata),
        .i_arc_addr   (arc_addr),
        .i_arc_we     (arc_we),
        .i_arc_wdata  (r_acc),
        .o_arc_rdata  (arc_rdata)
    );

endmodule

/* rtl/alpi_checker.sv */
// Port checker of the arc length path interpolator and its bind.
`include "arc_length_path_interpolator_defines.svh"

module alpi_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_stall,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input alpi_pkg::t_out i_out
);

    // An accepted word keeps the block busy in the next cycle.
    `ALPI_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !i_in_stall, i_in_stall)

    // A stalled result word holds.
    `ALPI_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out))

    // Pose and speed fields are zero unless the query succeeded.
    `ALPI_ASSERT_NOW(a_zero_fields, i_out_valid && i_out.status != alpi_pkg::ST_OK, (i_out.out_x == 32'sd0) && (i_out.out_y == 32'sd0) && (i_out.out_z == 32'sd0) && (i_out.out_roll == 32'sd0) && (i_out.out_pitch == 32'sd0) && (i_out.out_yaw == 32'sd0) && (i_out.out_speed_limit == 32'd0))

    // A cleared table reports no length.
    `ALPI_ASSERT_NOW(a_clear_len, i_out_valid && i_out.status == alpi_pkg::ST_CLEARED, i_out.total_length == 48'd0)

endmodule

bind arc_length_path_interpolator alpi_checker u_alpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

/* tb/sv/tb_arc_length_path_interpolator.sv */
// Testbench of the arc length path interpolator: random and directed words, scoreboard check.
`timescale 1ns / 1ps

module tb_arc_length_path_interpolator;

    localparam int NPTS = alpi_pkg::MAX_POINTS_DEF;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    alpi_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    alpi_pkg::t_out o_out;

    arc_length_path_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // Predicted path table.
    logic [31:0] path_pose [NPTS*6];
    logic [31:0] path_speed [NPTS];
    logic [47:0] path_arc [NPTS];
    int unsigned path_count;
    logic [47:0] path_total;

    alpi_pkg::t_in  word_queue [$];
    alpi_pkg::t_out expected_words [$];
    int   mismatch_count;
    bit   hold_sender;
    int   long_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Floor square root of a 66-bit value, one bit at a time.
    function automatic logic [47:0] floor_sqrt(input logic [65:0] n);
        logic [47:0]  root;
        logic [47:0]  trial;
        logic [95:0]  sq;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (48'd1 << b);
            sq = trial * trial;
            if (sq <= {30'd0, n}) root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] blend(input longint p0, input longint p1,
                                          input longint frac);
        longint prod;
        prod = frac * (p1 - p0);
        return 32'(p0 + (prod >>> 16));
    endfunction

    // Works out the result word of one input word and updates the table.
    function automatic alpi_pkg::t_out predict_path(input alpi_pkg::t_in w);
        alpi_pkg::t_out r;
        logic [65:0] sumsq;
        logic [32:0] d;
        logic [48:0] sum;
        logic [31:0] coord [3];
        longint s, lo, hi, mid, ia, ib, frac;
        logic [47:0] ds, off;
        r = '0;
        coord[0] = w.in_x;
        coord[1] = w.in_y;
        coord[2] = w.in_z;
        if (w.operation == alpi_pkg::OP_CLEAR) begin
            path_count = 0;
            path_total = '0;
            r.status = alpi_pkg::ST_CLEARED;
        end else if (w.operation == alpi_pkg::OP_LOAD) begin
            if (path_count >= NPTS) begin
                r.status = alpi_pkg::ST_FULL;
            end else begin
                if (path_count > 0) begin
                    sumsq = '0;
                    for (int c = 0; c < 3; c++) begin
                        s = longint'($signed(coord[c]))
                          - longint'($signed(path_pose[(path_count-1)*6 + c]));
                        d = (s < 0) ? 33'(-s) : 33'(s);
                        sumsq += 66'(d) * 66'(d);
                    end
                    sum = {1'b0, path_total} + 49'(floor_sqrt(sumsq));
                    path_total = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
                end
                path_pose[path_count*6 + 0] = w.in_x;
                path_pose[path_count*6 + 1] = w.in_y;
                path_pose[path_count*6 + 2] = w.in_z;
                path_pose[path_count*6 + 3] = w.in_roll;
                path_pose[path_count*6 + 4] = w.in_pitch;
                path_pose[path_count*6 + 5] = w.in_yaw;
                path_speed[path_count] = w.in_speed_limit;
                path_arc[path_count] = path_total;
                path_count++;
                r.status = alpi_pkg::ST_LOADED;
            end
        end else if (w.operation == alpi_pkg::OP_QUERY && path_count >= 2
                     && path_total != 0) begin
            s = longint'(w.arc_position);
            frac = 0;
            if (s <= 0) begin
                ia = 0; ib = 0;
            end else if (s >= longint'({16'd0, path_total})) begin
                ia = path_count - 1; ib = ia;
            end else begin
                lo = 0; hi = path_count;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (s < longint'({16'd0, path_arc[mid]})) hi = mid;
                    else lo = mid + 1;
                end
                if (lo == 0) lo = 1;
                if (lo >= path_count) lo = path_count - 1;
                ia = lo - 1; ib = lo;
                ds = path_arc[ib] - path_arc[ia];
                off = 48'(s) - path_arc[ia];
                if (ds > 0 && path_arc[ib] >= path_arc[ia] && off < ds)
                    frac = longint'(({16'd0, off} << 16) / {16'd0, ds});
            end
            r.out_x     = blend($signed(path_pose[ia*6+0]), $signed(path_pose[ib*6+0]), frac);
            r.out_y     = blend($signed(path_pose[ia*6+1]), $signed(path_pose[ib*6+1]), frac);
            r.out_z     = blend($signed(path_pose[ia*6+2]), $signed(path_pose[ib*6+2]), frac);
            r.out_roll  = blend($signed(path_pose[ia*6+3]), $signed(path_pose[ib*6+3]), frac);
            r.out_pitch = blend($signed(path_pose[ia*6+4]), $signed(path_pose[ib*6+4]), frac);
            r.out_yaw   = blend($signed(path_pose[ia*6+5]), $signed(path_pose[ib*6+5]), frac);
            r.out_speed_limit = blend(longint'(path_speed[ia]), longint'(path_speed[ib]), frac);
            r.status = alpi_pkg::ST_OK;
        end else begin
            r.status = alpi_pkg::ST_INVALID;
        end
        r.total_length = path_total;
        return r;
    endfunction

    // Random coordinate: mostly small steps, sometimes full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    function automatic alpi_pkg::t_in make_word(input logic [1:0] op);
        alpi_pkg::t_in w;
        w.operation = op;
        w.in_x = rand_coord(); w.in_y = rand_coord(); w.in_z = rand_coord();
        w.in_roll = $urandom(); w.in_pitch = $urandom(); w.in_yaw = $urandom();
        w.in_speed_limit = $urandom();
        w.arc_position = 48'({$urandom(), $urandom()});
        return w;
    endfunction

    // Query positions spread over the path, with the ends and out-of-range values.
    function automatic logic [47:0] rand_position();
        case ($urandom_range(0, 7))
            0: return 48'h8000_0000_0000;
            1: return 48'h7FFF_FFFF_FFFF;
            2: return 48'd0;
            3: return path_total;
            4: return 48'({$urandom(), $urandom()});
            default: return 48'(({$urandom(), $urandom()}) % ({16'd0, path_total} + 64'd1));
        endcase
    endfunction

    // The queue holds unpredicted words; the prediction runs when the block accepts one.
    int send_gap;
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        send_gap = 0;
    end

    // Driver: takes words from the queue, predicts at acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_words.push_back(predict_path(i_in));
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0 || hold_sender || word_queue.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in <= word_queue.pop_front();
                end
            end
        end
    end

    // Long receiver hold-off, counted down in cycles.
    always @(posedge i_clk) begin
        if (long_hold > 0) long_hold <= long_hold - 1;
    end

    // Monitor and receiver stall.
    int rx_gap;
    initial begin
        i_out_stall = 1'b0;
        rx_gap = 0;
    end
    always @(posedge i_clk) begin
        alpi_pkg::t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", 64'(o_out.status), 64'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (o_out.status !== want.status)
                        report_mismatch("status", 64'(o_out.status), 64'(want.status));
                    if (o_out.out_x !== want.out_x)
                        report_mismatch("out_x", 64'(o_out.out_x), 64'(want.out_x));
                    if (o_out.out_y !== want.out_y)
                        report_mismatch("out_y", 64'(o_out.out_y), 64'(want.out_y));
                    if (o_out.out_z !== want.out_z)
                        report_mismatch("out_z", 64'(o_out.out_z), 64'(want.out_z));
                    if (o_out.out_roll !== want.out_roll)
                        report_mismatch("out_roll", 64'(o_out.out_roll), 64'(want.out_roll));
                    if (o_out.out_pitch !== want.out_pitch)
                        report_mismatch("out_pitch", 64'(o_out.out_pitch), 64'(want.out_pitch));
                    if (o_out.out_yaw !== want.out_yaw)
                        report_mismatch("out_yaw", 64'(o_out.out_yaw), 64'(want.out_yaw));
                    if (o_out.out_speed_limit !== want.out_speed_limit)
                        report_mismatch("speed", 64'(o_out.out_speed_limit),
                                        64'(want.out_speed_limit));
                    if (o_out.total_length !== want.total_length)
                        report_mismatch("total", 64'(o_out.total_length),
                                        64'(want.total_length));
                end
                rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            end
            if (long_hold > 0) begin
                i_out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus. Query positions are picked from the predicted table as it stands after
    // the previous drain; the driver predicts each word at acceptance.
    task automatic wait_drained();
        while (word_queue.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        alpi_pkg::t_in w;
        int n;
        mismatch_count = 0;
        hold_sender = 1'b0;
        long_hold = 0;
        path_count = 0;
        path_total = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-path queries, unused selector, extremes, clamps, zero arc.
        word_queue.push_back(make_word(alpi_pkg::OP_QUERY));
        w = make_word(alpi_pkg::OP_RESERVED); word_queue.push_back(w);
        w = make_word(alpi_pkg::OP_LOAD); w.in_x = 32'h8000_0000; w.in_y = 32'h8000_0000;
        w.in_z = 32'h8000_0000; w.in_speed_limit = 32'h0; word_queue.push_back(w);
        word_queue.push_back(make_word(alpi_pkg::OP_QUERY));
        w = make_word(alpi_pkg::OP_LOAD); w.in_x = 32'h7FFF_FFFF; w.in_y = 32'h7FFF_FFFF;
        w.in_z = 32'h7FFF_FFFF; w.in_speed_limit = 32'hFFFF_FFFF; word_queue.push_back(w);
        w = make_word(alpi_pkg::OP_QUERY); w.arc_position = 48'h8000_0000_0000;
        word_queue.push_back(w);
        w.arc_position = 48'h7FFF_FFFF_FFFF; word_queue.push_back(w);
        w.arc_position = 48'h0001_0000_0000; word_queue.push_back(w);
        w.arc_position = 48'd1; word_queue.push_back(w);
        word_queue.push_back(make_word(alpi_pkg::OP_CLEAR));
        // Two coincident points: zero total arc is invalid.
        w = make_word(alpi_pkg::OP_LOAD); w.in_x = 32'h0; w.in_y = 32'h0; w.in_z = 32'h0;
        word_queue.push_back(w);
        word_queue.push_back(w);
        w.operation = alpi_pkg::OP_QUERY; w.arc_position = 48'd5; word_queue.push_back(w);
        // A repeated point gives a zero-length segment inside the path.
        w.operation = alpi_pkg::OP_LOAD; w.in_x = 32'h0003_0000; word_queue.push_back(w);
        word_queue.push_back(w);
        w.in_y = 32'h0004_0000; word_queue.push_back(w);
        w.operation = alpi_pkg::OP_QUERY; w.arc_position = 48'h0003_0000;
        word_queue.push_back(w);
        w.arc_position = 48'h0004_8000; word_queue.push_back(w);
        word_queue.push_back(make_word(alpi_pkg::OP_CLEAR));
        wait_drained();

        // Random: well-formed paths with queries, some noise. One fills the table.
        for (int p = 0; p < 10; p++) begin
            word_queue.push_back(make_word(alpi_pkg::OP_CLEAR));
            n = (p == 3) ? NPTS + 3 : $urandom_range(2, 30);
            for (int i = 0; i < n; i++) word_queue.push_back(make_word(alpi_pkg::OP_LOAD));
            if (p == 3) begin
                // Long receiver hold-off while the sender keeps offering.
                long_hold = 400;
            end
            wait_drained();
            for (int q = 0; q < ((p == 3) ? 200 : 60); q++) begin
                if ($urandom_range(0, 19) == 0) w = make_word(2'($urandom_range(0, 3)));
                else w = make_word(alpi_pkg::OP_QUERY);
                if (w.operation == alpi_pkg::OP_QUERY) w.arc_position = rand_position();
                if (w.operation == alpi_pkg::OP_CLEAR) w.operation = alpi_pkg::OP_QUERY;
                word_queue.push_back(w);
            end
            // Sender pauses until every expected word has come.
            wait_drained();
            hold_sender = 1'b1;
            repeat (5) @(posedge i_clk);
            hold_sender = 1'b0;
        end
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/alpi_pkg.sv
rtl/alpi_alu.sv
rtl/alpi_store.sv
rtl/arc_length_path_interpolator.sv
rtl/alpi_checker.sv
tb/sv/tb_arc_length_path_interpolator.sv
